// ===== rtl/front_coded_word_list_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the front-coded word list decoder
// Each macro expands to a clocked concurrent assertion on i_clk that is
// disabled while i_rst_n is low, or to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef FRONT_CODED_WORD_LIST_DECODER_ASSERT_SVH
`define FRONT_CODED_WORD_LIST_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FCWD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcwd assertion failed");

// Next-cycle implication.
`define FCWD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcwd assertion failed");

`else

`define FCWD_ASSERT_IMP(lbl, ante, cons)
`define FCWD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/fcwd_pkg.sv =====
// ---------------------------------------------------------------------------
// fcwd_pkg
// Shared types, constants and the controller/datapath command interface of
// the front-coded word list decoder.
// ---------------------------------------------------------------------------
package fcwd_pkg;

    // Default largest word held in the word store.
    localparam int MAX_WORD_DEF = 62;

    // Field widths.
    localparam int LEN_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int FILL_W  = 6;
    localparam int PFX_W   = 7;
    localparam int ERR_W   = 3;
    localparam int OUT_W   = 16;

    // Word-ending newline character.
    localparam logic [CHAR_W-1:0] NEWLINE = 7'd10;

    // Error codes carried on results.
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EARLY    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_PREFIX   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LONG     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd4;

    // Decoding phase.
    typedef enum logic [1:0] {
        PH_RUN,
        PH_DONE,
        PH_ERR
    } t_phase;

    // Datapath operations; every operation other than OP_NONE pushes one result.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_IDLE_DONE,
        OP_IDLE_ERR,
        OP_EMPTY,
        OP_FINISH,
        OP_FAIL_EOI,
        OP_FAIL_LONG,
        OP_CHAR,
        OP_PREFIX_ERR,
        OP_PREFIX,
        OP_REPLAY,
        OP_CUT
    } t_op;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        t_op  op;
        logic last;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic slot_free;
        logic phase_done;
        logic phase_err;
        logic tl_zero;
        logic near;
        logic near_next;
        logic eoi;
        logic is_char;
        logic fill_full;
        logic prefix_gt;
        logic prefix_zero;
        logic idx_last;
    } t_status;

endpackage

// ===== rtl/fcwd_ctrl.sv =====
// ---------------------------------------------------------------------------
// fcwd_ctrl
// Controller: takes one code byte at a time and sequences the results it
// causes (head result, prefix replay, final newline) into the datapath.
// ---------------------------------------------------------------------------
module fcwd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fcwd_pkg::t_status i_status,
    output fcwd_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_REPLAY,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.op    = fcwd_pkg::OP_NONE;
        o_cmd.last  = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_status.slot_free) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                    if (i_status.phase_done) begin
                        o_cmd.op = fcwd_pkg::OP_IDLE_DONE;
                    end else if (i_status.phase_err) begin
                        o_cmd.op = fcwd_pkg::OP_IDLE_ERR;
                    end else if (i_status.tl_zero) begin
                        o_cmd.op = fcwd_pkg::OP_EMPTY;
                    end else if (i_status.near) begin
                        o_cmd.op = fcwd_pkg::OP_FINISH;
                    end else if (i_status.eoi) begin
                        o_cmd.op = fcwd_pkg::OP_FAIL_EOI;
                    end else if (i_status.is_char) begin
                        if (i_status.fill_full) begin
                            o_cmd.op = fcwd_pkg::OP_FAIL_LONG;
                        end else begin
                            o_cmd.op = fcwd_pkg::OP_CHAR;
                            if (i_status.near_next) begin
                                o_cmd.last = 1'b0;
                                n_state    = S_FIN;
                            end
                        end
                    end else if (i_status.prefix_gt) begin
                        o_cmd.op = fcwd_pkg::OP_PREFIX_ERR;
                    end else begin
                        o_cmd.op = fcwd_pkg::OP_PREFIX;
                        if (!i_status.prefix_zero) begin
                            o_cmd.last = 1'b0;
                            n_state    = S_REPLAY;
                        end else if (i_status.near_next) begin
                            o_cmd.last = 1'b0;
                            n_state    = S_FIN;
                        end
                    end
                end
            end
            S_REPLAY: begin
                if (i_status.slot_free) begin
                    if (i_status.near) begin
                        // Replay would run past the list length: cut it short.
                        o_cmd.op   = fcwd_pkg::OP_CUT;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.op = fcwd_pkg::OP_REPLAY;
                        if (i_status.idx_last) begin
                            if (i_status.near_next) begin
                                n_state = S_FIN;
                            end else begin
                                o_cmd.last = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end
                    end
                end
            end
            S_FIN: begin
                if (i_status.slot_free) begin
                    o_cmd.op   = fcwd_pkg::OP_FINISH;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/fcwd_dp.sv =====
// ---------------------------------------------------------------------------
// fcwd_dp
// Datapath: word store, counters, sticky error, latched input beat and the
// output register that holds one result until it is taken.
// ---------------------------------------------------------------------------
module fcwd_dp #(
    parameter int MAX_WORD = fcwd_pkg::MAX_WORD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fcwd_pkg::LEN_W-1:0]    i_cfg_wdata,
    input  logic [fcwd_pkg::BYTE_W-1:0]   i_code_byte,
    input  logic                          i_eoi,
    input  fcwd_pkg::t_cmd                i_cmd,
    output fcwd_pkg::t_status             o_status,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fcwd_pkg::CHAR_W-1:0]   o_char,
    output logic                          o_has_char,
    output logic                          o_last,
    output logic                          o_done,
    output logic [fcwd_pkg::ERR_W-1:0]    o_err
);

    localparam int ADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    // Configuration and decoding state.
    logic [fcwd_pkg::LEN_W-1:0]  r_tl;
    logic [fcwd_pkg::LEN_W-1:0]  r_count;
    logic [fcwd_pkg::FILL_W-1:0] r_fill;
    fcwd_pkg::t_phase            r_phase;
    logic [fcwd_pkg::ERR_W-1:0]  r_sticky;

    // Latched input beat and replay position.
    logic [fcwd_pkg::BYTE_W-1:0] r_byte;
    logic                        r_eoi;
    logic [fcwd_pkg::PFX_W-1:0]  r_idx;

    // Word store with registered read data.
    logic [fcwd_pkg::CHAR_W-1:0] mem [MAX_WORD];
    logic [fcwd_pkg::CHAR_W-1:0] r_rdata;

    // Output register.
    logic                        r_ovalid;
    logic [fcwd_pkg::CHAR_W-1:0] r_ochar;
    logic                        r_ohas;
    logic                        r_olast;
    logic                        r_odone;
    logic [fcwd_pkg::ERR_W-1:0]  r_oerr;

    logic [fcwd_pkg::PFX_W-1:0]  prefix;
    logic [fcwd_pkg::PFX_W-1:0]  idx_next;
    logic [fcwd_pkg::LEN_W:0]    count_p1;
    logic [fcwd_pkg::LEN_W:0]    count_p2;
    logic [fcwd_pkg::LEN_W:0]    tl_ext;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        push;

    assign prefix   = r_byte[fcwd_pkg::PFX_W-1:0];
    assign idx_next = r_idx + 7'd1;
    assign count_p1 = {1'b0, r_count} + 25'd1;
    assign count_p2 = {1'b0, r_count} + 25'd2;
    assign tl_ext   = {1'b0, r_tl};
    assign push     = (i_cmd.op != fcwd_pkg::OP_NONE);

    // Status toward the controller.
    always_comb begin
        o_status.slot_free   = !r_ovalid || i_ready;
        o_status.phase_done  = (r_phase == fcwd_pkg::PH_DONE);
        o_status.phase_err   = (r_phase == fcwd_pkg::PH_ERR);
        o_status.tl_zero     = (r_tl == '0);
        o_status.near        = (count_p1 >= tl_ext);
        o_status.near_next   = (count_p2 >= tl_ext);
        o_status.eoi         = r_eoi;
        o_status.is_char     = !r_byte[fcwd_pkg::BYTE_W-1];
        o_status.fill_full   = (r_fill >= fcwd_pkg::FILL_W'(MAX_WORD));
        o_status.prefix_gt   = (prefix > {1'b0, r_fill});
        o_status.prefix_zero = (prefix == '0);
        o_status.idx_last    = (idx_next == prefix);
    end

    // Word store read: first entry on a prefix marker, then one ahead per replay.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.op == fcwd_pkg::OP_PREFIX) begin
            rd_en = 1'b1;
        end else if (i_cmd.op == fcwd_pkg::OP_REPLAY && idx_next < prefix) begin
            rd_en   = 1'b1;
            rd_addr = idx_next[ADDR_W-1:0];
        end
    end

    // Word store write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fcwd_pkg::OP_CHAR) begin
            mem[r_fill[ADDR_W-1:0]] <= r_byte[fcwd_pkg::CHAR_W-1:0];
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Input beat latch and replay index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_code_byte;
            r_eoi  <= i_eoi;
        end
        if (i_cmd.op == fcwd_pkg::OP_PREFIX) begin
            r_idx <= '0;
        end else if (i_cmd.op == fcwd_pkg::OP_REPLAY) begin
            r_idx <= idx_next;
        end
    end

    // Decoding state; a configuration write restarts the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl     <= '0;
            r_count  <= '0;
            r_fill   <= '0;
            r_phase  <= fcwd_pkg::PH_RUN;
            r_sticky <= fcwd_pkg::ERR_NONE;
        end else if (i_cfg_we) begin
            r_tl     <= i_cfg_wdata;
            r_count  <= '0;
            r_fill   <= '0;
            r_phase  <= fcwd_pkg::PH_RUN;
            r_sticky <= fcwd_pkg::ERR_NONE;
        end else begin
            case (i_cmd.op)
                fcwd_pkg::OP_EMPTY: begin
                    r_phase <= fcwd_pkg::PH_DONE;
                end
                fcwd_pkg::OP_FINISH: begin
                    r_count <= count_p1[fcwd_pkg::LEN_W-1:0];
                    r_phase <= fcwd_pkg::PH_DONE;
                end
                fcwd_pkg::OP_FAIL_EOI: begin
                    r_sticky <= fcwd_pkg::ERR_EARLY;
                    r_phase  <= fcwd_pkg::PH_ERR;
                end
                fcwd_pkg::OP_FAIL_LONG: begin
                    r_sticky <= fcwd_pkg::ERR_LONG;
                    r_phase  <= fcwd_pkg::PH_ERR;
                end
                fcwd_pkg::OP_CHAR: begin
                    r_fill  <= r_fill + 6'd1;
                    r_count <= count_p1[fcwd_pkg::LEN_W-1:0];
                end
                fcwd_pkg::OP_PREFIX_ERR: begin
                    r_count  <= count_p1[fcwd_pkg::LEN_W-1:0];
                    r_sticky <= fcwd_pkg::ERR_PREFIX;
                    r_phase  <= fcwd_pkg::PH_ERR;
                end
                fcwd_pkg::OP_PREFIX: begin
                    r_count <= count_p1[fcwd_pkg::LEN_W-1:0];
                    r_fill  <= prefix[fcwd_pkg::FILL_W-1:0];
                end
                fcwd_pkg::OP_REPLAY: begin
                    r_count <= count_p1[fcwd_pkg::LEN_W-1:0];
                end
                fcwd_pkg::OP_CUT: begin
                    r_count  <= count_p1[fcwd_pkg::LEN_W-1:0];
                    r_sticky <= fcwd_pkg::ERR_MISMATCH;
                    r_phase  <= fcwd_pkg::PH_ERR;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register valid: set on a push, cleared when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_olast <= i_cmd.last;
            r_ochar <= '0;
            r_ohas  <= 1'b0;
            r_odone <= 1'b0;
            r_oerr  <= fcwd_pkg::ERR_NONE;
            case (i_cmd.op)
                fcwd_pkg::OP_IDLE_DONE, fcwd_pkg::OP_EMPTY: begin
                    r_odone <= 1'b1;
                end
                fcwd_pkg::OP_IDLE_ERR: begin
                    r_oerr <= r_sticky;
                end
                fcwd_pkg::OP_FINISH: begin
                    r_ochar <= fcwd_pkg::NEWLINE;
                    r_ohas  <= 1'b1;
                    r_odone <= 1'b1;
                end
                fcwd_pkg::OP_FAIL_EOI: begin
                    r_oerr <= fcwd_pkg::ERR_EARLY;
                end
                fcwd_pkg::OP_FAIL_LONG: begin
                    r_oerr <= fcwd_pkg::ERR_LONG;
                end
                fcwd_pkg::OP_CHAR: begin
                    r_ochar <= r_byte[fcwd_pkg::CHAR_W-1:0];
                    r_ohas  <= 1'b1;
                end
                fcwd_pkg::OP_PREFIX_ERR: begin
                    r_ochar <= fcwd_pkg::NEWLINE;
                    r_ohas  <= 1'b1;
                    r_oerr  <= fcwd_pkg::ERR_PREFIX;
                end
                fcwd_pkg::OP_PREFIX: begin
                    r_ochar <= fcwd_pkg::NEWLINE;
                    r_ohas  <= 1'b1;
                end
                fcwd_pkg::OP_REPLAY: begin
                    r_ochar <= r_rdata;
                    r_ohas  <= 1'b1;
                end
                fcwd_pkg::OP_CUT: begin
                    r_ochar <= fcwd_pkg::NEWLINE;
                    r_ohas  <= 1'b1;
                    r_oerr  <= fcwd_pkg::ERR_MISMATCH;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_char     = r_ochar;
    assign o_has_char = r_ohas;
    assign o_last     = r_olast;
    assign o_done     = r_odone;
    assign o_err      = r_oerr;

endmodule

// ===== rtl/front_coded_word_list_decoder.sv =====
// ---------------------------------------------------------------------------
// front_coded_word_list_decoder
// Decodes a front-coded sorted word list, one code byte per input beat, into
// newline-terminated 7-bit characters with sticky error reporting.
// ---------------------------------------------------------------------------
// Each input beat is latched and then gives its results one per cycle, while
// the output is not stalled, through an output register: a plain character
// gives that character (and a final newline when it completes the list), and
// a prefix marker gives a newline, then replays the prefix from the word store
// through its single read port one character a cycle, and a final newline when
// the list completes. The input is not ready again until the last result of a
// beat is in the output register; a stalled output holds the controller.
// Writing the total length restarts decoding; write it only while no beat is
// in flight. The word store needs no clearing after reset.
module front_coded_word_list_decoder #(
    parameter int MAX_WORD = fcwd_pkg::MAX_WORD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: total decoded length
    input  logic                        i_cfg_we,
    input  logic [fcwd_pkg::LEN_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [fcwd_pkg::BYTE_W-1:0] i_s_axis_tdata,  // [7:0] code_byte
    input  logic                        i_s_axis_tuser,  // [0] end_of_input
    // Output stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [fcwd_pkg::OUT_W-1:0]  o_m_axis_tdata,  // [6:0] out_char, [7] list_done,
                                                         // [10:8] error_code, [15:11] zero
    output logic                        o_m_axis_tuser,  // [0] has_char
    output logic                        o_m_axis_tlast   // run_last
);

`include "front_coded_word_list_decoder_assert.svh"

    fcwd_pkg::t_cmd    cmd;
    fcwd_pkg::t_status status;

    logic [fcwd_pkg::CHAR_W-1:0] out_char;
    logic                        out_done;
    logic [fcwd_pkg::ERR_W-1:0]  out_err;

    // Sequencer.
    fcwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Storage, counters and output register.
    fcwd_dp #(
        .MAX_WORD (MAX_WORD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_code_byte (i_s_axis_tdata),
        .i_eoi       (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (out_char),
        .o_has_char  (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast),
        .o_done      (out_done),
        .o_err       (out_err)
    );

    // Result beat packing.
    assign o_m_axis_tdata = {5'd0, out_err, out_done, out_char};

    // Every accepted beat causes at least one result, so input closes at once.
    `FCWD_ASSERT_NXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready)

    // A result without a character carries a zero character.
    `FCWD_ASSERT_IMP(a_empty_char_zero, o_m_axis_tvalid && !o_m_axis_tuser,
        o_m_axis_tdata[6:0] == 7'd0)

    // A completed list never reports an error.
    `FCWD_ASSERT_IMP(a_done_no_error, o_m_axis_tvalid && o_m_axis_tdata[7],
        o_m_axis_tdata[10:8] == fcwd_pkg::ERR_NONE)

    // Error codes stay within the defined set.
    `FCWD_ASSERT_IMP(a_error_range, o_m_axis_tvalid,
        o_m_axis_tdata[10:8] <= fcwd_pkg::ERR_MISMATCH)

endmodule
